### sv/avgbs_pkg.sv
// Shared constants, types and helper functions of the averaging background subtractor.
package avgbs_pkg;

    localparam int FRAME_PIXELS = 65536;
    localparam int MEM_DEPTH    = (FRAME_PIXELS < 65536) ? FRAME_PIXELS : 65536;
    localparam int ADDR_W       = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CHANNELS     = 3;
    localparam int DIV_LANES    = 2 * CHANNELS;
    localparam int DIV_STEPS    = 40;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

    localparam logic [1:0] CMD_LEARN    = 2'd0;
    localparam logic [1:0] CMD_BUILD    = 2'd1;
    localparam logic [1:0] CMD_CLASSIFY = 2'd2;

    localparam logic [1:0] REG_LEARN_WEIGHT = 2'd0;
    localparam logic [1:0] REG_HIGH_SCALE   = 2'd1;
    localparam logic [1:0] REG_LOW_SCALE    = 2'd2;
    localparam logic [1:0] REG_DIFF_FLOOR   = 2'd3;

    localparam logic [8:0]  LEARN_WEIGHT_RST = 9'd256;
    localparam logic [11:0] HIGH_SCALE_RST   = 12'd768;
    localparam logic [11:0] LOW_SCALE_RST    = 12'd768;
    localparam logic [11:0] DIFF_FLOOR_RST   = 12'd256;
    localparam logic [23:0] WEIGHT_ONE       = 24'd256;
    localparam logic [23:0] WEIGHT_MAX       = 24'hFFFFFF;

    typedef struct packed {
        logic [CHANNELS-1:0][31:0] mean_sum;
        logic [CHANNELS-1:0][31:0] change_sum;
        logic [CHANNELS-1:0][7:0]  last_sample;
        logic [CHANNELS-1:0][23:0] upper_bound;
        logic [CHANNELS-1:0][23:0] lower_bound;
    } model_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        model_t            data;
    } ram_wr_t;

    function automatic logic [31:0] sat32(input logic [32:0] v);
        sat32 = v[32] ? 32'hFFFFFFFF : v[31:0];
    endfunction

endpackage

### sv/avgbs_model_ram.sv
// Per-pixel model memory with one write port and one registered read port.
module avgbs_model_ram
    import avgbs_pkg::*;
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output model_t            rd_data,
    input  ram_wr_t           wr
);

    model_t mem [MEM_DEPTH];
    model_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/avgbs_divider.sv
// Six-lane restoring divider, one quotient bit per lane per cycle, saturating quotients.
module avgbs_divider
    import avgbs_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [23:0]                     divisor,
    input  logic [DIV_LANES-1:0][39:0]      dividend,
    output logic                            done,
    output logic [DIV_LANES-1:0][31:0]      quotient
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [DIV_CNT_W-1:0]        cnt_reg, cnt_next;
    logic [23:0]                 div_reg;
    logic [DIV_LANES-1:0][23:0]  rem_reg, rem_next;
    logic [DIV_LANES-1:0][39:0]  q_reg, q_next;
    logic                        last_step;

    assign last_step = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    always_comb
    begin
        logic [24:0] shifted;
        logic        ge;
        for (int i = 0; i < DIV_LANES; i++)
        begin
            shifted     = {rem_reg[i], q_reg[i][39]};
            ge          = (shifted >= {1'b0, div_reg});
            rem_next[i] = ge ? 24'(shifted - {1'b0, div_reg}) : shifted[23:0];
            q_next[i]   = {q_reg[i][38:0], ge};
            quotient[i] = (q_reg[i][39:32] != 8'd0) ? 32'hFFFFFFFF : q_reg[i][31:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= divisor;
            rem_reg <= '0;
            q_reg   <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign done = done_reg;

endmodule

### sv/avgbs_build.sv
// Model build sequencer: divides the sums of one pixel and writes its thresholds back.
module avgbs_build
    import avgbs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [ADDR_W-1:0] addr,
    input  model_t            entry,
    input  logic [23:0]       frame_weight,
    input  logic [11:0]       high_scale,
    input  logic [11:0]       low_scale,
    input  logic [11:0]       difference_floor,
    output logic              busy,
    output ram_wr_t           wr
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_MUL   = 2'd2;
    localparam logic [1:0] ST_WRITE = 2'd3;

    localparam logic signed [37:0] S24_MAX_W = 38'sd8388607;
    localparam logic signed [37:0] S24_MIN_W = -38'sd8388608;

    logic [1:0]                     state_reg, state_next;
    logic [ADDR_W-1:0]              addr_reg;
    model_t                         entry_reg;
    logic [CHANNELS-1:0][31:0]      mean_reg, change_reg;
    logic [CHANNELS-1:0][43:0]      hi_prod_reg, lo_prod_reg;
    logic [DIV_LANES-1:0][39:0]     dividend;
    logic [DIV_LANES-1:0][31:0]     quotient;
    logic [23:0]                    divisor;
    logic                           div_done;
    model_t                         wr_data;

    assign divisor = (frame_weight == 24'd0) ? WEIGHT_ONE : frame_weight;

    always_comb
    begin
        for (int k = 0; k < CHANNELS; k++)
        begin
            dividend[k]            = {entry.mean_sum[k], 8'd0};
            dividend[k + CHANNELS] = {entry.change_sum[k], 8'd0};
        end
    end

    avgbs_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .divisor  (divisor),
        .dividend (dividend),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (start) state_next = ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_MUL;
            ST_MUL:   state_next = ST_WRITE;
            ST_WRITE: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            addr_reg  <= addr;
            entry_reg <= entry;
        end
        if (state_reg == ST_DIV && div_done)
        begin
            for (int k = 0; k < CHANNELS; k++)
            begin
                mean_reg[k]   <= quotient[k];
                change_reg[k] <= sat32({1'b0, quotient[k + CHANNELS]}
                                       + {21'd0, difference_floor});
            end
        end
        if (state_reg == ST_MUL)
        begin
            for (int k = 0; k < CHANNELS; k++)
            begin
                hi_prod_reg[k] <= change_reg[k] * high_scale;
                lo_prod_reg[k] <= change_reg[k] * low_scale;
            end
        end
    end

    always_comb
    begin
        logic [36:0]        up;
        logic signed [37:0] lo;
        wr_data             = entry_reg;
        wr_data.mean_sum    = mean_reg;
        wr_data.change_sum  = change_reg;
        for (int k = 0; k < CHANNELS; k++)
        begin
            up = {5'd0, mean_reg[k]} + {1'b0, hi_prod_reg[k][43:8]};
            lo = $signed({6'd0, mean_reg[k]}) - $signed({2'd0, lo_prod_reg[k][43:8]});
            wr_data.upper_bound[k] = (up > 37'd8388607) ? 24'h7FFFFF : up[23:0];
            if (lo > S24_MAX_W)
            begin
                wr_data.lower_bound[k] = 24'h7FFFFF;
            end
            else if (lo < S24_MIN_W)
            begin
                wr_data.lower_bound[k] = 24'h800000;
            end
            else
            begin
                wr_data.lower_bound[k] = lo[23:0];
            end
        end
    end

    assign busy    = (state_reg != ST_IDLE);
    assign wr.en   = (state_reg == ST_WRITE);
    assign wr.addr = addr_reg;
    assign wr.data = wr_data;

endmodule

### sv/average_background_subtractor_core.sv
// Top level of the averaging background subtractor: pixel pipeline, model memory and build unit.
//
// Requests arrive on the in_valid/in_ready channel, one pixel per request, with a
// command: learn folds the pixel into its running sums, build turns the sums of the
// pixel into upper and lower thresholds, classify compares the pixel with them.
// Only classify produces a response, on out_valid/out_ready, in request order.
// The cfg_valid/cfg_ready channel writes the four registers and is always ready;
// write it only while no request is in flight.
//
// Learn and classify requests are taken one per cycle while the read stage is not
// stalled. A classify request passes the memory read and the read-stage registers, which
// capture it as the request is accepted; then the compare lands in the output register.
// A build request reads the pixel, then holds the input while the six-lane divider
// runs and its quotients are scaled and written back; the next request is accepted
// once the write-back is done. Back-to-back accesses to one pixel are forwarded
// from the last write.
//
// Reset restores the register defaults, an empty model and a zero frame weight;
// the model memory itself is not cleared, and a pixel must be learned before it is
// built or classified. When the receiver stalls, the response waits in the output
// register and one more request can sit in the read stage behind it.
module average_background_subtractor_core
    import avgbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [15:0] pixel_index,
    input  logic [7:0]  blue,
    input  logic [7:0]  green,
    input  logic [7:0]  red,
    input  logic        frame_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] result_index,
    output logic        in_range_any,
    output logic        foreground,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    // Configuration registers.
    logic [8:0]  learn_weight_reg;
    logic [11:0] high_scale_reg, low_scale_reg, diff_floor_reg;

    // Global model state.
    logic [23:0] frame_weight_reg, frame_weight_next;
    logic        model_empty_reg, model_empty_next;

    // Read stage: the request whose memory data arrives this cycle.
    logic                     s1_valid_reg, s1_valid_next;
    logic [1:0]               s1_cmd_reg;
    logic [15:0]              s1_index_reg;
    logic [ADDR_W-1:0]        s1_addr_reg;
    logic                     s1_in_frame_reg;
    logic                     s1_frame_end_reg;
    logic [CHANNELS-1:0][7:0] s1_sample_reg;

    // Output register.
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_index_reg;
    logic        out_in_range_reg;

    // Forwarding of the most recent memory write.
    logic              fwd_valid_reg, fwd_valid_next;
    logic [ADDR_W-1:0] fwd_addr_reg;
    model_t            fwd_data_reg;

    logic    accept, s1_stall, s1_adv, build_start, build_busy, in_frame, any_in_range;
    model_t  rd_data, s1_entry, learn_entry;
    ram_wr_t learn_wr, build_wr, mem_wr;

    assign accept   = in_valid && in_ready;
    assign in_frame = ({16'd0, pixel_index} < 32'(FRAME_PIXELS));

    // A classify request can only leave the read stage if the output register frees up.
    assign s1_stall = s1_valid_reg && (s1_cmd_reg == CMD_CLASSIFY)
                      && out_valid_reg && !out_ready;
    assign s1_adv   = s1_valid_reg && !s1_stall;

    // A build in the read stage blocks intake until the build unit has written back.
    assign in_ready = !build_busy && !s1_stall
                      && !(s1_valid_reg && (s1_cmd_reg == CMD_BUILD));
    assign cfg_ready = 1'b1;

    avgbs_model_ram u_ram (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (pixel_index[ADDR_W-1:0]),
        .rd_data (rd_data),
        .wr      (mem_wr)
    );

    // The memory read missed a write made at the same edge; take the written data.
    assign s1_entry = (fwd_valid_reg && fwd_addr_reg == s1_addr_reg) ? fwd_data_reg : rd_data;

    // Learn update for all three channels.
    always_comb
    begin
        logic [7:0]  diff;
        logic [16:0] mean_add, change_add;
        learn_entry = s1_entry;
        for (int k = 0; k < CHANNELS; k++)
        begin
            diff = (s1_sample_reg[k] > s1_entry.last_sample[k])
                   ? s1_sample_reg[k] - s1_entry.last_sample[k]
                   : s1_entry.last_sample[k] - s1_sample_reg[k];
            mean_add   = learn_weight_reg * s1_sample_reg[k];
            change_add = learn_weight_reg * diff;
            if (model_empty_reg)
            begin
                learn_entry.mean_sum[k]   = {16'd0, s1_sample_reg[k], 8'd0};
                learn_entry.change_sum[k] = 32'd0;
            end
            else
            begin
                learn_entry.mean_sum[k]   = sat32({1'b0, s1_entry.mean_sum[k]}
                                                  + {16'd0, mean_add});
                learn_entry.change_sum[k] = sat32({1'b0, s1_entry.change_sum[k]}
                                                  + {16'd0, change_add});
            end
            learn_entry.last_sample[k] = s1_sample_reg[k];
        end
    end

    assign learn_wr.en   = s1_adv && (s1_cmd_reg == CMD_LEARN) && s1_in_frame_reg;
    assign learn_wr.addr = s1_addr_reg;
    assign learn_wr.data = learn_entry;

    // Only one writer is active in any cycle: the read stage is empty while building.
    assign mem_wr = build_wr.en ? build_wr : learn_wr;

    assign build_start = s1_adv && (s1_cmd_reg == CMD_BUILD) && s1_in_frame_reg;

    avgbs_build u_build (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (build_start),
        .addr             (s1_addr_reg),
        .entry            (s1_entry),
        .frame_weight     (frame_weight_reg),
        .high_scale       (high_scale_reg),
        .low_scale        (low_scale_reg),
        .difference_floor (diff_floor_reg),
        .busy             (build_busy),
        .wr               (build_wr)
    );

    // Classification: the pixel is in range if any channel sits between its thresholds.
    always_comb
    begin
        logic signed [23:0] p;
        any_in_range = 1'b0;
        for (int k = 0; k < CHANNELS; k++)
        begin
            p = $signed({8'd0, s1_sample_reg[k], 8'd0});
            if (p >= $signed(s1_entry.lower_bound[k]) && p <= $signed(s1_entry.upper_bound[k]))
            begin
                any_in_range = 1'b1;
            end
        end
        any_in_range = any_in_range && s1_in_frame_reg;
    end

    // Frame-level state changes once the last pixel of a frame passes the read stage.
    always_comb
    begin
        logic [24:0] w_sum;
        frame_weight_next = frame_weight_reg;
        model_empty_next  = model_empty_reg;
        w_sum = {1'b0, frame_weight_reg} + {16'd0, learn_weight_reg};
        if (s1_adv && s1_frame_end_reg)
        begin
            case (s1_cmd_reg)
                CMD_LEARN:
                begin
                    frame_weight_next = w_sum[24] ? WEIGHT_MAX : w_sum[23:0];
                    model_empty_next  = 1'b0;
                end
                CMD_BUILD:
                begin
                    frame_weight_next = WEIGHT_ONE;
                end
                default:
                begin
                    frame_weight_next = frame_weight_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next  = accept ? 1'b1 : (s1_stall ? s1_valid_reg : 1'b0);
        fwd_valid_next = mem_wr.en ? 1'b1 : (s1_stall ? fwd_valid_reg : 1'b0);
        if (s1_adv && s1_cmd_reg == CMD_CLASSIFY)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_weight_reg <= LEARN_WEIGHT_RST;
            high_scale_reg   <= HIGH_SCALE_RST;
            low_scale_reg    <= LOW_SCALE_RST;
            diff_floor_reg   <= DIFF_FLOOR_RST;
            frame_weight_reg <= 24'd0;
            model_empty_reg  <= 1'b1;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            fwd_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_LEARN_WEIGHT: learn_weight_reg <= cfg_data[8:0];
                    REG_HIGH_SCALE:   high_scale_reg   <= cfg_data;
                    REG_LOW_SCALE:    low_scale_reg    <= cfg_data;
                    REG_DIFF_FLOOR:   diff_floor_reg   <= cfg_data;
                    default:          learn_weight_reg <= learn_weight_reg;
                endcase
            end
            frame_weight_reg <= frame_weight_next;
            model_empty_reg  <= model_empty_next;
            s1_valid_reg     <= s1_valid_next;
            out_valid_reg    <= out_valid_next;
            fwd_valid_reg    <= fwd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg       <= command;
            s1_index_reg     <= pixel_index;
            s1_addr_reg      <= pixel_index[ADDR_W-1:0];
            s1_in_frame_reg  <= in_frame;
            s1_frame_end_reg <= frame_end;
            s1_sample_reg    <= {red, green, blue};
        end
        if (mem_wr.en)
        begin
            fwd_addr_reg <= mem_wr.addr;
            fwd_data_reg <= mem_wr.data;
        end
        if (s1_adv && s1_cmd_reg == CMD_CLASSIFY)
        begin
            out_index_reg    <= s1_index_reg;
            out_in_range_reg <= any_in_range;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_index = out_index_reg;
    assign in_range_any = out_in_range_reg;
    assign foreground   = !out_in_range_reg;

endmodule

### sv/avgbs_checker.sv
// Port-level checker of the averaging background subtractor, bound to the top level.
module avgbs_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] result_index,
    input logic        in_range_any,
    input logic        foreground
);

    // A response holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_index))
        else $error("response dropped or changed while stalled");

    // The two flags of a response always disagree.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (foreground != in_range_any))
        else $error("foreground is not the inverse of in_range_any");

    // A fresh response follows an accepted request through the read stage and the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("response without a matching request");

    // No response appears without a request accepted ahead of it through the read stage and output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid ##1 out_valid |-> $past(in_valid && in_ready, 2))
        else $error("response appeared with no request in flight");

endmodule

bind average_background_subtractor_core avgbs_checker u_avgbs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_index (result_index),
    .in_range_any (in_range_any),
    .foreground   (foreground)
);

### verif/tb_average_background_subtractor_core.sv
// Self-checking testbench of the averaging background subtractor core.
`timescale 1ns / 100ps

module tb_average_background_subtractor_core;
    import avgbs_pkg::*;

    // Command code that the block must ignore without a response.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // Cycles to let a build request finish before a register write.
    localparam int BUILD_SETTLE = 60;
    // Cycles with no handshake on any channel before the run is abandoned.
    localparam int STALL_LIMIT = 5000;
    // Length of the long receiver hold-off, in cycles.
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_PCT = 15;
    localparam int PHASE_ITEMS = 180;

    typedef struct packed {
        logic [1:0]      cmd;
        logic [15:0]     pix;
        logic [2:0][7:0] smp;   // index 0 blue, 1 green, 2 red
        logic            fe;
    } pixel_req_t;

    typedef struct packed {
        logic [15:0] pix;
        logic        in_range;
    } verdict_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  command;
    logic [15:0] pixel_index;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic        frame_end;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] result_index;
    logic        in_range_any;
    logic        foreground;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [11:0] cfg_data;

    average_background_subtractor_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .pixel_index (pixel_index),
        .blue        (blue),
        .green       (green),
        .red         (red),
        .frame_end   (frame_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_index(result_index),
        .in_range_any(in_range_any),
        .foreground  (foreground),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Requests waiting to be offered, and verdicts of accepted classify requests.
    pixel_req_t pending_reqs[$];
    verdict_t   pending_verdicts[$];
    int         fail_count = 0;

    // Random idling is switched off while calm is set.
    bit calm = 1'b0;
    // Once raised, the receiver holds off for HOLD_CYCLES and then resumes.
    bit recv_hold_go = 1'b0;
    bit recv_hold_done = 1'b0;

    // Shadow of the background model, keyed by pixel * 3 + channel.
    logic [31:0] mean_mem[int];
    logic [31:0] change_mem[int];
    logic [7:0]  last_mem[int];
    longint      upper_mem[int];
    longint      lower_mem[int];
    logic [23:0] frame_wt;
    bit          model_empty;
    logic [8:0]  learn_wt;
    logic [11:0] high_scl;
    logic [11:0] low_scl;
    logic [11:0] diff_floor;

    // Pixels used by the random part; all are learned and built in the directed part.
    logic [15:0] pixel_pool[8] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd100, 16'd4095,
                                   16'd32768, 16'd65535};

    function automatic logic [31:0] clip32(longint unsigned v);
        return (v > 64'hFFFFFFFF) ? 32'hFFFFFFFF : v[31:0];
    endfunction

    function automatic longint clip24(longint v);
        if (v > 64'sd8388607)
            return 64'sd8388607;
        if (v < -64'sd8388608)
            return -64'sd8388608;
        return v;
    endfunction

    // Advances the model by one accepted request and queues its verdict, if any.
    function automatic void track_pixel(pixel_req_t r);
        int             c;
        longint unsigned w;
        longint unsigned m;
        longint unsigned d;
        longint unsigned p;
        logic [7:0]     dif;
        bit             any;
        logic [24:0]    wsum;
        any = 1'b0;
        case (r.cmd)
            CMD_LEARN:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    c = r.pix * 3 + k;
                    if (model_empty)
                    begin
                        mean_mem[c] = {16'd0, r.smp[k], 8'd0};
                        change_mem[c] = 32'd0;
                    end
                    else
                    begin
                        dif = (r.smp[k] > last_mem[c]) ? r.smp[k] - last_mem[c]
                                                       : last_mem[c] - r.smp[k];
                        mean_mem[c] = clip32(longint'(mean_mem[c]) + learn_wt * r.smp[k]);
                        change_mem[c] = clip32(longint'(change_mem[c]) + learn_wt * dif);
                    end
                    last_mem[c] = r.smp[k];
                end
                if (r.fe)
                begin
                    wsum = frame_wt + learn_wt;
                    frame_wt = wsum[24] ? WEIGHT_MAX : wsum[23:0];
                    model_empty = 1'b0;
                end
            end
            CMD_BUILD:
            begin
                // A zero frame weight divides by one, leaving the sums as they are.
                w = (frame_wt == 0) ? 256 : frame_wt;
                for (int k = 0; k < 3; k++)
                begin
                    c = r.pix * 3 + k;
                    m = clip32((longint'(mean_mem[c]) << 8) / w);
                    d = clip32((longint'(change_mem[c]) << 8) / w);
                    d = clip32(d + diff_floor);
                    mean_mem[c] = m[31:0];
                    change_mem[c] = d[31:0];
                    upper_mem[c] = clip24(longint'(m) + longint'((d * high_scl) >> 8));
                    lower_mem[c] = clip24(longint'(m) - longint'((d * low_scl) >> 8));
                end
                if (r.fe)
                    frame_wt = WEIGHT_ONE;
            end
            CMD_CLASSIFY:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    c = r.pix * 3 + k;
                    p = r.smp[k] * 256;
                    if (longint'(p) >= lower_mem[c] && longint'(p) <= upper_mem[c])
                        any = 1'b1;
                end
                pending_verdicts.push_back('{pix: r.pix, in_range: any});
            end
            default:
            begin
                // The unused command is ignored, frame end included.
            end
        endcase
    endfunction

    // Driver: offers queued requests, holding each one until it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        pixel_req_t nxt;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            command     <= CMD_LEARN;
            pixel_index <= '0;
            blue        <= '0;
            green       <= '0;
            red         <= '0;
            frame_end   <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                track_pixel('{cmd: command, pix: pixel_index,
                              smp: {red, green, blue}, fe: frame_end});
            if (!in_valid || in_ready)
            begin
                if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt = pending_reqs.pop_front();
                    in_valid    <= 1'b1;
                    command     <= nxt.cmd;
                    pixel_index <= nxt.pix;
                    blue        <= nxt.smp[0];
                    green       <= nxt.smp[1];
                    red         <= nxt.smp[2];
                    frame_end   <= nxt.fe;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each response against the oldest verdict and drives out_ready.
    always @(posedge clk or negedge rst_n)
    begin
        int       hold_count;
        verdict_t want;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            hold_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $error("response for pixel %0d with no classify request pending",
                           result_index);
                    fail_count++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (result_index !== want.pix)
                    begin
                        $error("result_index expected %0d actual %0d", want.pix, result_index);
                        fail_count++;
                    end
                    if (in_range_any !== want.in_range)
                    begin
                        $error("in_range_any expected %0d actual %0d", want.in_range,
                               in_range_any);
                        fail_count++;
                    end
                    if (foreground !== !want.in_range)
                    begin
                        $error("foreground expected %0d actual %0d", !want.in_range,
                               foreground);
                        fail_count++;
                    end
                end
            end
            if (recv_hold_go && !recv_hold_done)
            begin
                hold_count++;
                if (hold_count >= HOLD_CYCLES)
                    recv_hold_done = 1'b1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: a long run of cycles with no handshake on any channel is a hang.
    always @(posedge clk)
    begin
        int quiet;
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [7:0] pick_sample();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic void queue_pixel(logic [1:0] cmd, logic [15:0] pix,
                                        logic [7:0] b, logic [7:0] g, logic [7:0] r,
                                        logic fe);
        pending_reqs.push_back('{cmd: cmd, pix: pix, smp: {r, g, b}, fe: fe});
    endfunction

    // Random traffic over the pool: every pixel there is learned and built already.
    function automatic void queue_random(int count);
        int         roll;
        logic [1:0] cmd;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 40)
                cmd = CMD_LEARN;
            else if (roll < 55)
                cmd = CMD_BUILD;
            else if (roll < 95)
                cmd = CMD_CLASSIFY;
            else
                cmd = CMD_UNUSED;
            queue_pixel(cmd, pixel_pool[$urandom_range(7)], pick_sample(), pick_sample(),
                        pick_sample(), $urandom_range(9) == 0);
        end
    endfunction

    // Waits until all requests are accepted and all responses are in, then lets a
    // build that produces no response run out before the block is touched again.
    task automatic drain();
        while (pending_reqs.size() > 0 || in_valid || pending_verdicts.size() > 0)
            @(posedge clk);
        repeat (BUILD_SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [11:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_LEARN_WEIGHT: learn_wt   = value[8:0];
            REG_HIGH_SCALE:   high_scl   = value;
            REG_LOW_SCALE:    low_scl    = value;
            default:          diff_floor = value;
        endcase
    endtask

    task automatic set_regs(logic [11:0] lw, logic [11:0] hs, logic [11:0] ls,
                            logic [11:0] fl);
        write_reg(REG_LEARN_WEIGHT, lw);
        write_reg(REG_HIGH_SCALE, hs);
        write_reg(REG_LOW_SCALE, ls);
        write_reg(REG_DIFF_FLOOR, fl);
    endtask

    initial
    begin
        frame_wt    = '0;
        model_empty = 1'b1;
        learn_wt    = LEARN_WEIGHT_RST;
        high_scl    = HIGH_SCALE_RST;
        low_scl     = LOW_SCALE_RST;
        diff_floor  = DIFF_FLOOR_RST;
        cfg_valid   = 1'b0;
        cfg_index   = REG_LEARN_WEIGHT;
        cfg_data    = '0;
        rst_n       = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. A pixel learned and built before any frame has ended sees a
        // zero frame weight, so its sums pass through the divide unchanged.
        queue_pixel(CMD_LEARN, 16'd5, 8'd10, 8'd128, 8'd250, 1'b0);
        queue_pixel(CMD_BUILD, 16'd5, 8'd0, 8'd0, 8'd0, 1'b0);
        queue_pixel(CMD_CLASSIFY, 16'd5, 8'd10, 8'd0, 8'd0, 1'b0);
        // The first learned frame copies samples; it ends on its last pixel.
        for (int i = 0; i < 8; i++)
            queue_pixel(CMD_LEARN, pixel_pool[i], (i == 7) ? 8'd255 : 8'(i * 37),
                        (i == 7) ? 8'd255 : 8'(i * 11), (i == 0) ? 8'd0 : 8'(255 - i),
                        i == 7);
        queue_pixel(CMD_LEARN, 16'd65535, 8'd0, 8'd128, 8'd255, 1'b1);
        for (int i = 0; i < 8; i++)
            queue_pixel(CMD_BUILD, pixel_pool[i], 8'd0, 8'd0, 8'd0, i == 7);
        queue_pixel(CMD_CLASSIFY, 16'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        queue_pixel(CMD_CLASSIFY, 16'd65535, 8'd255, 8'd255, 8'd255, 1'b0);
        queue_pixel(CMD_UNUSED, 16'd1, 8'd255, 8'd0, 8'd255, 1'b1);
        queue_pixel(CMD_CLASSIFY, 16'd65535, 8'd0, 8'd255, 8'd128, 1'b1);
        drain();

        // Reset settings, with random idling on both sides.
        queue_random(PHASE_ITEMS);
        drain();

        // Every register at its low end.
        set_regs(12'd0, 12'd0, 12'd0, 12'd0);
        queue_random(PHASE_ITEMS);
        drain();

        // Every register at its high end; learn weight beyond 1.0.
        set_regs(12'd511, 12'd4095, 12'd4095, 12'd4095);
        queue_random(PHASE_ITEMS);
        drain();

        // No idling, and the receiver holds off long enough for the block to fill
        // and stall its input while requests keep coming.
        set_regs(12'd128, 12'd1000, 12'd300, 12'd64);
        calm = 1'b1;
        recv_hold_go = 1'b1;
        queue_random(PHASE_ITEMS);
        drain();
        calm = 1'b0;

        set_regs(12'($urandom_range(256)), 12'($urandom_range(4095)),
                 12'($urandom_range(4095)), 12'($urandom_range(4095)));
        queue_random(PHASE_ITEMS);
        drain();

        set_regs(12'd256, 12'd768, 12'd768, 12'd256);
        queue_random(PHASE_ITEMS);
        drain();

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
